/* hw/rtl/rcmcs_pkg.sv */
// Package for the RGB column matrix command scroller.
// Holds codes, splash image, rate table and shared types; no dependencies.
package rcmcs_pkg;

    localparam int DefColumns = 16;

    // input action codes
    localparam logic [1:0] ACT_RX   = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_TX    = 2'd1;
    localparam logic [1:0] KIND_COL   = 2'd2;
    localparam logic [1:0] KIND_RESET = 2'd3;

    // scroll modes
    localparam logic [3:0] MODE_NONE    = 4'd0;
    localparam logic [3:0] MODE_RIGHT   = 4'd1;
    localparam logic [3:0] MODE_LEFT    = 4'd2;
    localparam logic [3:0] MODE_UP      = 4'd3;
    localparam logic [3:0] MODE_DOWN    = 4'd4;
    localparam logic [3:0] MODE_RIGHT_R = 4'd5;
    localparam logic [3:0] MODE_LEFT_R  = 4'd6;
    localparam logic [3:0] MODE_UP_R    = 4'd7;
    localparam logic [3:0] MODE_DOWN_R  = 4'd8;

    // command bytes and masks
    localparam logic [7:0] CMD_COLUMN = 8'h40;
    localparam logic [7:0] CMD_CLEAR  = 8'h00;
    localparam logic [7:0] CMD_DUMP   = 8'h5A;
    localparam logic [7:0] CMD_PONG   = 8'h7E;
    localparam logic [7:0] CMD_BAUD   = 8'h08;
    localparam logic [7:0] CMD_RATE   = 8'h20;
    localparam logic [7:0] CMD_SCROLL = 8'h10;
    localparam logic [7:0] MASK_HI    = 8'hF0;
    localparam logic [7:0] MASK_BAUD  = 8'hF8;
    localparam logic [7:0] CH_OPEN    = 8'h5B;
    localparam logic [7:0] CH_CLOSE   = 8'h5D;
    localparam logic [7:0] CH_PING    = 8'h3F;

    // reset values
    localparam logic [6:0] RST_SCROLL = 7'd76;
    localparam logic [7:0] RST_PING   = 8'd38;
    localparam logic [7:0] RST_CREDIT = 8'd50;
    localparam logic [2:0] RST_BAUD   = 3'd7;
    localparam logic [1:0] RST_PRESC  = 2'd2;

    // frame operations handed down the cell chain
    typedef enum logic [2:0] {
        FOP_HOLD, FOP_LOAD, FOP_CLEAR, FOP_WRITE, FOP_SHIFT, FOP_ROTATE, FOP_BITS
    } t_fop;

    typedef struct packed {
        t_fop       op;
        logic       fwd;      // shift towards higher columns
        logic [3:0] mode;     // bit scroll mode
        logic [3:0] col;      // write column
        logic [1:0] chan;     // write channel 0..2
        logic [7:0] data;     // write byte
    } t_fcmd;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    function automatic t_rgb splash_col(input int c);
        logic [7:0] s [0:47];
        t_rgb v;
        s = '{8'h3F,8'h00,8'h00,8'h05,8'h00,8'h00,8'h01,8'h00,8'hF0,8'h00,8'h00,8'h80,
              8'h00,8'h3E,8'h00,8'h00,8'h2A,8'h00,8'h00,8'h00,8'h00,8'hF0,8'hF0,8'h00,
              8'h90,8'h90,8'h00,8'h60,8'h60,8'h00,8'h00,8'h04,8'h04,8'h00,8'h2A,8'h2A,
              8'h00,8'h2A,8'h2A,8'h00,8'h10,8'h10,8'h00,8'h00,8'h00,8'hBC,8'h00,8'hBC};
        v.r = s[3*c];
        v.g = s[3*c+1];
        v.b = s[3*c+2];
        return v;
    endfunction

    // rate table entry: {prescale, scroll reload, ping reload}
    function automatic logic [16:0] rate_entry(input logic [3:0] f);
        logic [16:0] e;
        case (f)
            4'd0:  e = {2'd0, 7'd1,  8'd229};
            4'd1:  e = {2'd1, 7'd1,  8'd115};
            4'd2:  e = {2'd0, 7'd3,  8'd230};
            4'd3:  e = {2'd2, 7'd1,  8'd57};
            4'd4:  e = {2'd0, 7'd5,  8'd229};
            4'd5:  e = {2'd1, 7'd3,  8'd115};
            4'd6:  e = {2'd0, 7'd7,  8'd231};
            4'd7:  e = {2'd2, 7'd2,  8'd57};
            4'd8:  e = {2'd0, 7'd9,  8'd230};
            4'd9:  e = {2'd2, 7'd3,  8'd56};
            4'd10: e = {2'd0, 7'd17, 8'd230};
            4'd11: e = {2'd2, 7'd5,  8'd56};
            4'd12: e = {2'd2, 7'd8,  8'd60};
            4'd13: e = {2'd2, 7'd9,  8'd54};
            4'd14: e = {2'd2, 7'd14, 8'd53};
            default: e = {2'd2, 7'd76, 8'd57};
        endcase
        return e;
    endfunction

    function automatic logic [3:0] mode_of_cmd(input logic [2:0] m);
        logic [3:0] r;
        case (m)
            3'd0: r = MODE_DOWN_R;
            3'd1: r = MODE_DOWN;
            3'd2: r = MODE_UP_R;
            3'd3: r = MODE_UP;
            3'd4: r = MODE_LEFT_R;
            3'd5: r = MODE_LEFT;
            3'd6: r = MODE_RIGHT_R;
            default: r = MODE_RIGHT;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/rcmcs_cell.sv */
// One frame-store column: three colour bytes, updated from the shared command.
// Depends on rcmcs_pkg.
module rcmcs_cell
    import rcmcs_pkg::*;
#(
    parameter int Index = 0
) (
    input  logic  i_clk,
    input  t_fcmd i_cmd,
    input  t_rgb  i_lower,   // neighbour towards column 0
    input  t_rgb  i_upper,   // neighbour away from column 0
    output t_rgb  o_col
);

    t_rgb r_col;
    t_rgb n_col;

    function automatic logic [7:0] bitop(input logic [7:0] v, input logic [3:0] m);
        logic [7:0] o;
        case (m)
            MODE_UP:     o = {1'b0, v[7:1]};
            MODE_DOWN:   o = {v[6:0], 1'b0};
            MODE_UP_R:   o = {v[0], v[7:1]};
            MODE_DOWN_R: o = {v[6:0], v[7]};
            default:     o = v;
        endcase
        return o;
    endfunction

    // next column value
    always_comb begin
        n_col = r_col;
        case (i_cmd.op)
            FOP_LOAD:  n_col = splash_col(Index);
            FOP_CLEAR: n_col = '0;
            FOP_WRITE: begin
                if (i_cmd.col == 4'(Index)) begin
                    if (i_cmd.chan == 2'd0) n_col.r = i_cmd.data;
                    if (i_cmd.chan == 2'd1) n_col.g = i_cmd.data;
                    if (i_cmd.chan == 2'd2) n_col.b = i_cmd.data;
                end
            end
            FOP_SHIFT, FOP_ROTATE: n_col = i_cmd.fwd ? i_lower : i_upper;
            FOP_BITS: begin
                n_col.r = bitop(r_col.r, i_cmd.mode);
                n_col.g = bitop(r_col.g, i_cmd.mode);
                n_col.b = bitop(r_col.b, i_cmd.mode);
            end
            default: n_col = r_col;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_col <= n_col;
    end

    assign o_col = r_col;

endmodule

/* hw/rtl/rgb_column_matrix_command_scroller_unit.sv */
// Top level of the RGB column matrix command scroller.
// Depends on rcmcs_pkg and rcmcs_cell (one cell per column).
//
// Takes serial command bytes, timer ticks and column reads, one transaction at
// a time, and returns one or more result transactions per input. Each input
// goes from S_IDLE through S_EXEC (and S_DUMP for a dump) to S_OUT, where a
// reset request that follows a ping is also sent, before the next is taken;
// a frame dump sends 2 + 3*COLUMNS results, one per cycle when the output is
// taken, since it walks the column chain with the mux on the dump counter.
// During reset the frame store loads the splash image.
module rgb_column_matrix_command_scroller_unit
    import rcmcs_pkg::*;
#(
    parameter int COLUMNS = DefColumns
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // data_byte[7:0], read_column[11:8]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // tx_byte, red, green, blue, baud[34:32],
                                        // prescale[36:35], link[37]
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    output logic        m_axis_tlast
);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DUMP, S_OUT} t_state;

    t_state     r_state;
    logic [1:0] r_act;
    logic [7:0] r_data;
    logic [3:0] r_rcol;
    logic [1:0] r_phase;
    logic [3:0] r_tcol;
    logic       r_sen;
    logic [3:0] r_mode;
    logic [6:0] r_scd, r_srl;
    logic [7:0] r_pcd, r_prl, r_credit;
    logic [2:0] r_baud;
    logic [1:0] r_presc;
    logic       r_link;
    logic [5:0] r_didx;      // dump position: set to 1 with the open, 1..3C bytes, 3C+1 close
    logic       r_ping;      // reset request still to send after the ping
    logic       r_ovalid;
    logic [1:0] r_okind;
    logic [7:0] r_otx;
    t_rgb       r_orgb;
    logic       r_olast;

    localparam int FB = 3 * COLUMNS;

    t_fcmd cmd;
    t_rgb  cols [COLUMNS];

    // column chain
    for (genvar c = 0; c < COLUMNS; c++) begin : g_col
        rcmcs_cell #(.Index(c)) u_cell (
            .i_clk  (i_clk),
            .i_cmd  (cmd),
            .i_lower(c == 0 ? ((cmd.op == FOP_ROTATE) ? cols[COLUMNS-1] : t_rgb'('0))
                            : cols[(c == 0) ? 0 : c-1]),
            .i_upper(c == COLUMNS-1 ? ((cmd.op == FOP_ROTATE) ? cols[0] : t_rgb'('0))
                                    : cols[(c == COLUMNS-1) ? c : c+1]),
            .o_col  (cols[c])
        );
    end

    logic out_free;
    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free && i_rst_n;

    // dump byte select
    logic [5:0] bi;
    logic [7:0] dump_byte;
    always_comb begin
        bi = r_didx - 6'd1;
        dump_byte = 8'h00;
        for (int c = 0; c < COLUMNS; c++) begin
            if (bi == 6'(3*c))   dump_byte = cols[c].r;
            if (bi == 6'(3*c+1)) dump_byte = cols[c].g;
            if (bi == 6'(3*c+2)) dump_byte = cols[c].b;
        end
    end

    // tick arithmetic
    logic [7:0] pcd_dec;
    logic [6:0] scd_dec;
    logic       sc_fire;
    assign pcd_dec = r_pcd - 8'd1;
    assign scd_dec = r_scd - 7'd1;
    assign sc_fire = r_sen && (scd_dec == 7'd0);

    // frame command for this cycle
    always_comb begin
        cmd = '{op: FOP_HOLD, fwd: 1'b0, mode: r_mode, col: r_tcol,
                chan: r_phase - 2'd1, data: r_data};
        if (!i_rst_n) begin
            cmd.op = FOP_LOAD;
        end else if (r_state == S_EXEC) begin
            if (r_act == ACT_RX) begin
                if (r_phase != 2'd0) cmd.op = FOP_WRITE;
                else if (r_data == CMD_CLEAR) cmd.op = FOP_CLEAR;
            end else if (r_act == ACT_TICK) begin
                if (pcd_dec == 8'd0 && r_credit == 8'd0) cmd.op = FOP_LOAD;
                else if (sc_fire) begin
                    case (r_mode)
                        MODE_RIGHT:   begin cmd.op = FOP_SHIFT;  cmd.fwd = 1'b1; end
                        MODE_RIGHT_R: begin cmd.op = FOP_ROTATE; cmd.fwd = 1'b1; end
                        MODE_LEFT:    cmd.op = FOP_SHIFT;
                        MODE_LEFT_R:  cmd.op = FOP_ROTATE;
                        MODE_UP, MODE_DOWN, MODE_UP_R, MODE_DOWN_R: cmd.op = FOP_BITS;
                        default:      cmd.op = FOP_HOLD;
                    endcase
                end
            end
        end
    end

    logic [16:0] rent;
    assign rent = rate_entry(r_data[3:0]);

    // control and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= 2'd0;
            r_tcol   <= 4'd0;
            r_sen    <= 1'b0;
            r_mode   <= MODE_NONE;
            r_scd    <= RST_SCROLL;
            r_srl    <= RST_SCROLL;
            r_pcd    <= RST_PING;
            r_prl    <= RST_PING;
            r_credit <= RST_CREDIT;
            r_baud   <= RST_BAUD;
            r_presc  <= RST_PRESC;
            r_link   <= 1'b0;
            r_ovalid <= 1'b0;
            r_didx   <= '0;
            r_ping   <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_act   <= s_axis_tuser;
                        r_data  <= s_axis_tdata[7:0];
                        r_rcol  <= s_axis_tdata[11:8];
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_okind <= KIND_ACK;
                    r_otx   <= 8'h00;
                    r_orgb  <= '0;
                    r_olast <= 1'b1;
                    r_state <= S_OUT;
                    case (r_act)
                        ACT_RX: begin
                            r_link <= 1'b1;
                            if (r_phase != 2'd0) begin
                                r_phase <= r_phase + 2'd1;
                            end else if ((r_data & MASK_HI) == CMD_COLUMN) begin
                                r_tcol  <= r_data[3:0];
                                r_phase <= 2'd1;
                            end else if (r_data == CMD_DUMP) begin
                                r_okind <= KIND_TX;
                                r_otx   <= CH_OPEN;
                                r_olast <= 1'b0;
                                r_didx  <= 6'd1;
                                r_state <= S_DUMP;
                            end else if (r_data == CMD_PONG) begin
                                r_credit <= r_prl;
                            end else if ((r_data & MASK_BAUD) == CMD_BAUD) begin
                                r_baud <= r_data[2:0];
                            end else if ((r_data & MASK_HI) == CMD_RATE) begin
                                r_presc <= rent[16:15];
                                r_srl   <= rent[14:8];
                                r_prl   <= rent[7:0];
                                r_scd   <= rent[14:8];
                                r_pcd   <= rent[7:0];
                            end else if ((r_data & MASK_HI) == CMD_SCROLL) begin
                                if (!r_data[3]) begin
                                    r_mode <= mode_of_cmd(r_data[2:0]);
                                    r_sen  <= 1'b1;
                                end else begin
                                    r_sen <= (r_data[3:0] == 4'd8);
                                end
                            end
                        end
                        ACT_TICK: begin
                            r_link <= 1'b0;
                            r_pcd  <= pcd_dec;
                            if (pcd_dec == 8'd0) begin
                                r_okind <= KIND_TX;
                                r_otx   <= CH_PING;
                                r_pcd   <= r_prl;
                                if (r_credit == 8'd0) begin
                                    // missed pongs: full reset, then request
                                    r_olast  <= 1'b0;
                                    r_ping   <= 1'b1;
                                    r_phase  <= 2'd0;
                                    r_tcol   <= 4'd0;
                                    r_sen    <= 1'b0;
                                    r_mode   <= MODE_NONE;
                                    r_scd    <= RST_SCROLL;
                                    r_srl    <= RST_SCROLL;
                                    r_pcd    <= RST_PING;
                                    r_prl    <= RST_PING;
                                    r_credit <= RST_CREDIT;
                                    r_baud   <= RST_BAUD;
                                    r_presc  <= RST_PRESC;
                                end else begin
                                    r_credit <= r_credit - 8'd1;
                                end
                            end
                            if (!(pcd_dec == 8'd0 && r_credit == 8'd0) && r_sen) begin
                                r_scd <= scd_dec;
                                if (scd_dec == 7'd0) begin
                                    r_scd <= r_srl;
                                    if (r_mode == MODE_NONE || r_mode > MODE_DOWN_R)
                                        r_sen <= 1'b0;
                                end
                            end
                        end
                        ACT_READ: begin
                            r_okind <= KIND_COL;
                            if (32'(r_rcol) < COLUMNS) r_orgb <= cols[r_rcol[$clog2(COLUMNS)-1:0]];
                        end
                        default: ;
                    endcase
                    r_ovalid <= 1'b1;
                end
                S_DUMP: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_TX;
                        if (r_didx == 6'(FB + 1)) begin
                            r_otx   <= CH_CLOSE;
                            r_olast <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_otx   <= dump_byte;
                            r_didx  <= r_didx + 6'd1;
                        end
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        if (r_ping) begin
                            r_ping   <= 1'b0;
                            r_ovalid <= 1'b1;
                            r_okind  <= KIND_RESET;
                            r_otx    <= 8'h00;
                            r_olast  <= 1'b1;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {2'd0, r_link, r_presc, r_baud,
                            r_orgb.b, r_orgb.g, r_orgb.r, r_otx};

    // a result never appears from idle
    a_no_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !($rose(r_ovalid))) else $error("result from idle");
    // no input accepted while a result waits
    a_accept_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> out_free) else $error("accept while busy");
    // dump index stays in range
    a_dump_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> (r_didx <= 6'(FB + 1))) else $error("dump index");

endmodule

/* sim/rgb_column_matrix_command_scroller_unit_chk.sv */
// Checker for the RGB column matrix command scroller.
// Watches both stream channels, predicts results and compares; uses rcmcs_pkg.
module rgb_column_matrix_command_scroller_unit_chk
    import rcmcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_in_data,   // data_byte[7:0], read_column[11:8]
    input  logic [1:0]  i_in_user,   // action[1:0]
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [39:0] i_out_data,  // tx, r, g, b, baud, prescale, link
    input  logic [1:0]  i_out_user,  // kind[1:0]
    input  logic        i_out_last,
    output int          o_errors,
    output int          o_pending
);

    localparam int NCOL   = 16;
    localparam int NBYTES = 3 * NCOL;

    // expected transaction: kind, data word, last
    typedef struct packed {
        logic [1:0]  kind;
        logic [39:0] word;
        logic        last;
    } t_res;

    t_res        exp_q[$];
    logic [7:0]  fb [0:NBYTES-1];
    logic [1:0]  phase;
    logic [3:0]  tcol;
    logic        scr_en;
    logic [3:0]  smode;
    logic [6:0]  scd, srl;
    logic [7:0]  pcd, prl, credit;
    logic [2:0]  baud;
    logic [1:0]  presc;
    logic        link;
    logic [1:0]  kinds [$];
    logic [7:0]  txs [$];
    logic [23:0] rgbs [$];

    assign o_pending = exp_q.size();

    function automatic logic [7:0] splash_byte(input int i);
        t_rgb c;
        c = splash_col(i / 3);
        return (i % 3 == 0) ? c.r : (i % 3 == 1) ? c.g : c.b;
    endfunction

    task automatic model_reset();
        for (int i = 0; i < NBYTES; i++) fb[i] = splash_byte(i);
        phase = 0; tcol = 0; scr_en = 0; smode = MODE_NONE;
        scd = RST_SCROLL; srl = RST_SCROLL; pcd = RST_PING; prl = RST_PING;
        credit = RST_CREDIT; baud = RST_BAUD; presc = RST_PRESC; link = 0;
    endtask

    task automatic push_res(input logic [1:0] k, input logic [7:0] tx, input logic [23:0] c);
        kinds.push_back(k); txs.push_back(tx); rgbs.push_back(c);
    endtask

    // advance the frame by one scroll step
    task automatic scroll_step();
        logic [7:0] t [0:NBYTES-1];
        for (int i = 0; i < NBYTES; i++) t[i] = fb[i];
        case (smode)
            MODE_RIGHT, MODE_RIGHT_R: for (int i = 0; i < NBYTES; i++)
                fb[i] = (i >= 3) ? t[i-3] : (smode == MODE_RIGHT ? 8'd0 : t[NBYTES-3+i]);
            MODE_LEFT, MODE_LEFT_R: for (int i = 0; i < NBYTES; i++)
                fb[i] = (i < NBYTES-3) ? t[i+3] :
                        (smode == MODE_LEFT ? 8'd0 : t[i-(NBYTES-3)]);
            MODE_UP:     for (int i = 0; i < NBYTES; i++) fb[i] = t[i] >> 1;
            MODE_DOWN:   for (int i = 0; i < NBYTES; i++) fb[i] = t[i] << 1;
            MODE_UP_R:   for (int i = 0; i < NBYTES; i++) fb[i] = {t[i][0], t[i][7:1]};
            MODE_DOWN_R: for (int i = 0; i < NBYTES; i++) fb[i] = {t[i][6:0], t[i][7]};
            default: scr_en = 0;
        endcase
    endtask

    task automatic predict_item(input logic [1:0] act, input logic [7:0] v, input logic [3:0] rc);
        logic [16:0] e;
        logic [3:0]  m;
        logic        done;
        logic [3:0]  cmode [0:7];
        t_res        r;
        cmode = '{MODE_DOWN_R, MODE_DOWN, MODE_UP_R, MODE_UP,
                  MODE_LEFT_R, MODE_LEFT, MODE_RIGHT_R, MODE_RIGHT};
        kinds.delete(); txs.delete(); rgbs.delete();
        done = 0;
        if (act == ACT_RX) begin
            link = 1;
            if (phase != 0) begin
                fb[tcol*3 + phase - 1] = v;
                phase = phase + 2'd1;
                push_res(KIND_ACK, 0, 0);
            end else if (v == CMD_DUMP) begin
                push_res(KIND_TX, CH_OPEN, 0);
                for (int i = 0; i < NBYTES; i++) push_res(KIND_TX, fb[i], 0);
                push_res(KIND_TX, CH_CLOSE, 0);
            end else begin
                if ((v & MASK_HI) == CMD_COLUMN) begin
                    tcol = v[3:0]; phase = 1;
                end else if (v == CMD_CLEAR) begin
                    for (int i = 0; i < NBYTES; i++) fb[i] = 0;
                end else if (v == CMD_PONG) begin
                    credit = prl;
                end else if ((v & MASK_BAUD) == CMD_BAUD) begin
                    baud = v[2:0];
                end else if ((v & MASK_HI) == CMD_RATE) begin
                    e = rate_entry(v[3:0]);
                    presc = e[16:15]; srl = e[14:8]; prl = e[7:0];
                    scd = srl; pcd = prl;
                end else if ((v & MASK_HI) == CMD_SCROLL) begin
                    m = v[3:0];
                    if (m < 8) begin
                        smode = cmode[m[2:0]]; scr_en = 1;
                    end else scr_en = (m == 8);
                end
                push_res(KIND_ACK, 0, 0);
            end
        end else if (act == ACT_TICK) begin
            link = 0;
            pcd = pcd - 8'd1;
            if (pcd == 0) begin
                push_res(KIND_TX, CH_PING, 0);
                pcd = prl;
                if (credit == 0) begin
                    model_reset();
                    push_res(KIND_RESET, 0, 0);
                    done = 1;
                end else credit = credit - 8'd1;
            end
            if (!done && scr_en) begin
                scd = scd - 7'd1;
                if (scd == 0) begin
                    scroll_step();
                    scd = srl;
                end
            end
            if (kinds.size() == 0) push_res(KIND_ACK, 0, 0);
        end else if (act == ACT_READ) begin
            push_res(KIND_COL, 0, {fb[rc*3], fb[rc*3+1], fb[rc*3+2]});
        end else begin
            push_res(KIND_ACK, 0, 0);
        end
        // status fields show the state after the whole item
        for (int k = 0; k < kinds.size(); k++) begin
            r.kind = kinds[k];
            r.word = {2'd0, link, presc, baud, rgbs[k][7:0], rgbs[k][15:8],
                      rgbs[k][23:16], txs[k]};
            r.last = (k == kinds.size() - 1);
            exp_q.push_back(r);
        end
    endtask

    // watch both channels, predict on input and compare on output
    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            model_reset();
            exp_q.delete();
            o_errors <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (exp_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected transaction: kind %0d data %h last %0d",
                                 i_out_user, i_out_data, i_out_last);
                    o_errors <= o_errors + 1;
                end else begin
                    e = exp_q.pop_front();
                    if (e.kind !== i_out_user || e.word !== i_out_data ||
                        e.last !== i_out_last) begin
                        if (o_errors < 10)
                            $display("mismatch: exp kind %0d data %h last %0d, got %0d %h %0d",
                                     e.kind, e.word, e.last, i_out_user, i_out_data,
                                     i_out_last);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_item(i_in_user, i_in_data[7:0], i_in_data[11:8]);
        end
    end

endmodule

/* sim/rgb_column_matrix_command_scroller_unit_tb.sv */
// Testbench top for the RGB column matrix command scroller.
// Drives stimulus and the receiver; depends on rcmcs_pkg and the checker module.
module rgb_column_matrix_command_scroller_unit_tb;
    import rcmcs_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid, s_ready;
    logic [15:0] s_data;   // data_byte[7:0], read_column[11:8]
    logic [1:0]  s_user;   // action[1:0]
    logic        m_valid, m_ready;
    logic [39:0] m_data;   // tx, r, g, b, baud, prescale, link
    logic [1:0]  m_user;   // kind[1:0]
    logic        m_last;
    int          errors, pending;
    int          cycles;
    logic        hold_rx;
    logic        long_stall;

    rgb_column_matrix_command_scroller_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
        .s_axis_tdata(s_data), .s_axis_tuser(s_user),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
        .m_axis_tdata(m_data), .m_axis_tuser(m_user), .m_axis_tlast(m_last)
    );

    rgb_column_matrix_command_scroller_unit_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_valid), .i_in_ready(s_ready), .i_in_data(s_data), .i_in_user(s_user),
        .i_out_valid(m_valid), .i_out_ready(m_ready), .i_out_data(m_data),
        .i_out_user(m_user), .i_out_last(m_last),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 400000) begin
                $display("** rgb_column_matrix_command_scroller_unit: FAILED **");
                $finish;
            end
        end
    end

    // receiver: own stall pattern, plus one long hold-off when asked
    initial begin
        int mode;
        m_ready = 0;
        mode = 0;
        hold_rx = 0;
        forever begin
            @(negedge i_clk);
            if (long_stall) begin
                long_stall = 0;
                hold_rx = 1;
                m_ready <= 0;
                repeat (300) @(negedge i_clk);
                hold_rx = 0;
            end
            if (($urandom_range(0, 63)) == 0) mode = $urandom_range(0, 2);
            case (mode)
                0: m_ready <= 1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // offer one transaction and wait for acceptance
    task automatic send_item(input logic [1:0] act, input logic [7:0] v, input logic [3:0] c);
        s_valid <= 1;
        s_user  <= act;
        s_data  <= {4'd0, c, v};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
        if (g != 0) begin
            s_valid <= 0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        s_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    // random command with random content, including stray bytes and undefined actions
    task automatic rand_cmd();
        int p;
        logic [7:0] v;
        p = $urandom_range(0, 99);
        if (p < 22) begin
            send_item(ACT_RX, CMD_COLUMN | 8'($urandom_range(0, 15)), 0);
            repeat (3) send_item(ACT_RX, 8'($urandom), 0);
        end else if (p < 42) send_item(ACT_TICK, 8'($urandom), 4'($urandom));
        else if (p < 55) send_item(ACT_READ, 8'($urandom), 4'($urandom));
        else if (p < 62) send_item(ACT_RX, CMD_SCROLL | 8'($urandom_range(0, 15)), 0);
        else if (p < 67) send_item(ACT_RX, CMD_RATE | 8'($urandom_range(0, 15)), 0);
        else if (p < 71) send_item(ACT_RX, CMD_BAUD | 8'($urandom_range(0, 7)), 0);
        else if (p < 76) send_item(ACT_RX, CMD_PONG, 0);
        else if (p < 79) send_item(ACT_RX, CMD_DUMP, 0);
        else if (p < 81) send_item(ACT_RX, CMD_CLEAR, 0);
        else if (p < 83) send_item(2'd3, 8'($urandom), 4'($urandom));
        else begin
            v = 8'($urandom);
            send_item(ACT_RX, v, 0);
        end
    endtask

    initial begin
        int n;
        s_valid = 0; s_data = 0; s_user = 0; long_stall = 0;
        i_rst_n = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1;
        repeat (3) @(negedge i_clk);

        // directed: reads, writes at extremes, dump, every mode, rate, baud
        send_item(ACT_READ, 0, 4'd0);
        send_item(ACT_READ, 8'hFF, 4'd15);
        send_item(ACT_RX, CMD_DUMP, 0);
        send_item(ACT_RX, CMD_COLUMN | 8'd15, 0);
        send_item(ACT_RX, 8'hFF, 0);
        send_item(ACT_RX, 8'h00, 0);
        send_item(ACT_RX, 8'hA5, 0);
        send_item(ACT_READ, 0, 4'd15);
        send_item(ACT_RX, CMD_BAUD, 0);
        send_item(ACT_RX, CMD_BAUD | 8'd7, 0);
        send_item(ACT_RX, CMD_RATE, 0);
        send_item(ACT_RX, 8'hFF, 0);
        send_item(2'd3, 8'hFF, 4'd15);
        for (int m = 0; m < 8; m++) begin
            send_item(ACT_RX, CMD_SCROLL | 8'(m), 0);
            send_item(ACT_TICK, 0, 0);
        end
        send_item(ACT_RX, CMD_SCROLL | 8'd15, 0);
        send_item(ACT_RX, CMD_CLEAR, 0);
        drain();

        // fill up while the receiver holds off
        long_stall = 1;
        for (int i = 0; i < 6; i++) send_item(ACT_RX, CMD_DUMP, 0);
        drain();

        // random part; short rates so pings and scrolls occur
        n = 0;
        while (n < 190) begin
            if (n % 80 == 0) begin
                send_item(ACT_RX, CMD_RATE | 8'($urandom_range(12, 14)), 0);
                send_item(ACT_RX, CMD_SCROLL | 8'($urandom_range(0, 7)), 0);
            end
            rand_cmd();
            idle_gap();
            n++;
        end
        send_item(ACT_READ, 0, 4'd0);
        drain();

        if (errors == 0)
            $display("** rgb_column_matrix_command_scroller_unit: PASSED **");
        else
            $display("** rgb_column_matrix_command_scroller_unit: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/rcmcs_pkg.sv
hw/rtl/rcmcs_cell.sv
hw/rtl/rgb_column_matrix_command_scroller_unit.sv
sim/rgb_column_matrix_command_scroller_unit_chk.sv
sim/rgb_column_matrix_command_scroller_unit_tb.sv
